// File: src/sfm_pkg.sv
// shared constants, types and weight table of the ssim frame metric unit
package sfm_pkg;

    localparam int MaxWidth     = 2048;
    localparam int Window       = 11;
    localparam int Radius       = Window / 2;
    localparam int Span         = 2 * Radius + 1;
    localparam int ColBits      = $clog2(MaxWidth);
    localparam int SlotBits     = $clog2(Span);
    localparam int TapBits      = $clog2(Span);
    localparam int LineAddrBits = SlotBits + ColBits;
    localparam int LineDepth    = Span * MaxWidth;
    localparam int SlotRecip    = (2 ** 24 + Span - 1) / Span;

    localparam int DivNumBits = 64;
    localparam int DivDenBits = 52;
    localparam int DivCntBits = $clog2(DivNumBits + 1);

    localparam logic [11:0] WidthReset  = 12'd640;
    localparam logic [11:0] HeightReset = 12'd480;

    localparam logic signed [27:0] C1Q7 = 28'sd832;
    localparam logic signed [27:0] C2Q7 = 28'sd7491;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_index;

    typedef logic [15:0] t_tap_table [Span];

    function automatic longint gauss_raw(input int d);
        case (d)
            0: gauss_raw = 65536;
            1: gauss_raw = 52477;
            2: gauss_raw = 26943;
            3: gauss_raw = 8869;
            4: gauss_raw = 1872;
            5: gauss_raw = 253;
            6: gauss_raw = 22;
            7: gauss_raw = 1;
            default: gauss_raw = 0;
        endcase
    endfunction

    function automatic longint gauss_total();
        longint tot;
        tot = gauss_raw(0);
        for (int d = 1; d <= Radius; d++) begin
            tot = tot + 2 * gauss_raw(d);
        end
        return tot;
    endfunction

    localparam longint GaussTot = gauss_total();

    // normalized Q0.16 side weights
    localparam longint TapW1 = (gauss_raw(1) * 65536 + GaussTot / 2) / GaussTot;
    localparam longint TapW2 = (gauss_raw(2) * 65536 + GaussTot / 2) / GaussTot;
    localparam longint TapW3 = (gauss_raw(3) * 65536 + GaussTot / 2) / GaussTot;
    localparam longint TapW4 = (gauss_raw(4) * 65536 + GaussTot / 2) / GaussTot;
    localparam longint TapW5 = (gauss_raw(5) * 65536 + GaussTot / 2) / GaussTot;
    localparam longint TapW6 = (gauss_raw(6) * 65536 + GaussTot / 2) / GaussTot;
    localparam longint TapW7 = (gauss_raw(7) * 65536 + GaussTot / 2) / GaussTot;

    function automatic longint tap_side(input int d);
        case (d)
            1: tap_side = TapW1;
            2: tap_side = TapW2;
            3: tap_side = TapW3;
            4: tap_side = TapW4;
            5: tap_side = TapW5;
            6: tap_side = TapW6;
            7: tap_side = TapW7;
            default: tap_side = 0;
        endcase
    endfunction

    // center takes the rounding slack
    function automatic t_tap_table build_taps();
        t_tap_table tbl;
        longint side;
        side = 0;
        for (int d = 1; d <= Radius; d++) begin
            tbl[Radius + d] = 16'(tap_side(d));
            tbl[Radius - d] = 16'(tap_side(d));
            side = side + tap_side(d);
        end
        tbl[Radius] = 16'(65536 - 2 * side);
        return tbl;
    endfunction

    localparam t_tap_table TapTable = build_taps();

    typedef struct packed {
        logic accept;
        logic row_init;
        logic vcol_init;
        logic refl_row;
        logic vread;
        logic vsq;
        logic vmac;
        logic vstore;
        logic hcol_init;
        logic refl_col;
        logic hread;
        logic hmac;
        logic s_mean;
        logic s_mul1;
        logic s_term;
        logic s_mul2;
        logic s_div;
        logic s_acc;
        logic row_next;
        logic m_div;
        logic m_res;
    } t_cmd;

    typedef struct packed {
        logic row_end;
        logic rows_pending;
        logic frame_end;
        logic refl_done;
        logic tap_last;
        logic col_last;
        logic row_last;
        logic div_busy;
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROW_CHK,
        ST_V_COL,
        ST_V_RSTART,
        ST_V_RWAIT,
        ST_V_SQ,
        ST_V_MAC,
        ST_V_STORE,
        ST_H_COL,
        ST_H_RSTART,
        ST_H_RWAIT,
        ST_H_MAC,
        ST_S_MEAN,
        ST_S_MUL1,
        ST_S_TERM,
        ST_S_MUL2,
        ST_S_DIV,
        ST_S_DWAIT,
        ST_ROW_NEXT,
        ST_M_DIV,
        ST_M_DWAIT,
        ST_OUT
    } t_state;

endpackage

// File: src/sfm_divider.sv
// restoring divider, one quotient bit per cycle
module sfm_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sfm_pkg::DivNumBits-1:0]  i_dividend,
    input  logic [sfm_pkg::DivDenBits-1:0]  i_divisor,
    output logic                            o_busy,
    output logic [sfm_pkg::DivNumBits-1:0]  o_quotient
);

    logic                           r_busy;
    logic [sfm_pkg::DivCntBits-1:0] r_cnt;
    logic [sfm_pkg::DivDenBits:0]   r_rem;
    logic [sfm_pkg::DivNumBits-1:0] r_quo;
    logic [sfm_pkg::DivDenBits-1:0] r_den;
    logic [sfm_pkg::DivDenBits:0]   trial;
    logic                           fits;

    always_comb begin
        trial = {r_rem[sfm_pkg::DivDenBits-1:0], r_quo[sfm_pkg::DivNumBits-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= sfm_pkg::DivCntBits'(sfm_pkg::DivNumBits);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == sfm_pkg::DivCntBits'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[sfm_pkg::DivNumBits-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: src/sfm_datapath.sv
// line stores, window sums, ssim terms and frame accumulator
module sfm_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [11:0]            i_cfg_wdata,
    input  logic [7:0]             i_ref_pixel,
    input  logic [7:0]             i_test_pixel,
    input  sfm_pkg::t_cmd          i_cmd,
    output sfm_pkg::t_status       o_status,
    output logic signed [17:0]     o_frame_ssim
);

    localparam int CB = sfm_pkg::ColBits;
    localparam int TB = sfm_pkg::TapBits;
    localparam int SB = sfm_pkg::SlotBits;

    function automatic logic [SB-1:0] slot_of(input logic [11:0] row);
        logic [35:0] prod;
        logic [11:0] quo;
        logic [15:0] rem;
        prod    = 36'(row) * 36'(sfm_pkg::SlotRecip);
        quo     = prod[35:24];
        rem     = 16'(row) - 16'(quo) * 16'(sfm_pkg::Span);
        slot_of = rem[SB-1:0];
    endfunction

    // Q.32 to Q.7, nearest with ties away from zero
    function automatic logic signed [27:0] round_q25(input logic signed [51:0] v);
        logic [51:0] mag;
        logic [51:0] r;
        mag = v[51] ? unsigned'(-v) : unsigned'(v);
        r   = (mag + 52'h100_0000) >> 25;
        round_q25 = v[51] ? -$signed(28'(r)) : $signed(28'(r));
    endfunction

    // configuration and raster position
    logic [11:0]        r_width_cfg;
    logic [11:0]        r_height_cfg;
    logic [11:0]        eff_w;
    logic [11:0]        eff_h;
    logic [11:0]        wm1;
    logic [CB-1:0]      r_col;
    logic [11:0]        r_row;
    logic signed [41:0] r_sum;
    logic [CB-1:0]      col_cur;
    logic               row_end;
    logic               last_row;
    logic               row_ge;

    // rows to work on
    logic [11:0]        r_prow;
    logic [11:0]        r_plast;
    logic               r_any;
    logic               r_frame_end;

    // column and tap counters
    logic [CB-1:0]      r_c;
    logic [TB-1:0]      r_tap;
    logic [15:0]        k;

    // border mirroring
    logic signed [14:0] r_rm;
    logic signed [14:0] r_rp;
    logic [11:0]        r_rn;
    logic signed [14:0] refl_i;
    logic [11:0]        refl_n;
    logic               refl_start;
    logic               refl_done;
    logic [11:0]        refl_val;

    // memories
    logic [15:0]                        mem_line [sfm_pkg::LineDepth];
    logic [15:0]                        r_line_q;
    logic [sfm_pkg::LineAddrBits-1:0]   wr_addr;
    logic [sfm_pkg::LineAddrBits-1:0]   rd_addr;
    logic [159:0]                       mem_col [sfm_pkg::MaxWidth];
    logic [159:0]                       r_col_q;

    // vertical pass
    logic [15:0] r_sq [5];
    logic [31:0] r_vacc [5];

    // horizontal pass
    logic [31:0] colq [5];
    logic [47:0] hprod [5];
    logic [47:0] r_hacc [5];

    // per pixel terms
    logic [23:0]         r_m1;
    logic [23:0]         r_m2;
    logic [47:0]         r_p12;
    logic [47:0]         r_p11;
    logic [47:0]         r_p22;
    logic signed [51:0]  ta_raw;
    logic signed [51:0]  tb_raw;
    logic signed [51:0]  tp_raw;
    logic signed [51:0]  tq_raw;
    logic signed [27:0]  r_ta;
    logic signed [27:0]  r_tb;
    logic signed [27:0]  r_tp;
    logic signed [27:0]  r_tq;
    logic signed [55:0]  den_prod;
    logic signed [55:0]  r_num;
    logic signed [55:0]  r_den;
    logic [55:0]         num_mag;
    logic [55:0]         den_mag;
    logic                r_sat;
    logic                r_neg;
    logic [16:0]         pix_mag;
    logic signed [17:0]  pix_val;
    logic [41:0]         sum_mag;
    logic [23:0]         area;
    logic [17:0]         mean_mag;
    logic signed [17:0]  r_frame_ssim;

    // divider
    logic                              div_start;
    logic [sfm_pkg::DivNumBits-1:0]    div_dividend;
    logic [sfm_pkg::DivDenBits-1:0]    div_divisor;
    logic                              div_busy;
    logic [sfm_pkg::DivNumBits-1:0]    div_q;

    always_comb begin
        if (r_width_cfg == 12'd0) begin
            eff_w = 12'd1;
        end else if (r_width_cfg > 12'(sfm_pkg::MaxWidth)) begin
            eff_w = 12'(sfm_pkg::MaxWidth);
        end else begin
            eff_w = r_width_cfg;
        end
        eff_h    = (r_height_cfg == 12'd0) ? 12'd1 : r_height_cfg;
        wm1      = eff_w - 12'd1;
        col_cur  = ({1'b0, r_col} > wm1) ? wm1[CB-1:0] : r_col;
        row_end  = (col_cur == wm1[CB-1:0]);
        last_row = ({1'b0, r_row} + 13'd1) >= {1'b0, eff_h};
        row_ge   = r_row >= 12'(sfm_pkg::Radius);
        k        = sfm_pkg::TapTable[r_tap];
    end

    // mirror unit: fold the index into one period, then onto the frame
    always_comb begin
        refl_start = i_cmd.refl_row | i_cmd.refl_col;
        if (i_cmd.refl_row) begin
            refl_i = $signed({3'b000, r_prow}) + $signed({{(15-TB){1'b0}}, r_tap})
                   - $signed(15'(sfm_pkg::Radius));
            refl_n = eff_h;
        end else begin
            refl_i = $signed({{(15-CB){1'b0}}, r_c}) + $signed({{(15-TB){1'b0}}, r_tap})
                   - $signed(15'(sfm_pkg::Radius));
            refl_n = eff_w;
        end
        refl_done = (r_rm >= 15'sd0) && (r_rm < r_rp);
        refl_val  = ($signed({3'b000, r_rn}) <= r_rm) ? 12'(r_rp - r_rm) : 12'(r_rm);
    end

    always_ff @(posedge i_clk) begin
        if (refl_start) begin
            r_rn <= refl_n;
            if (refl_n <= 12'd1) begin
                r_rm <= 15'sd0;
                r_rp <= 15'sd2;
            end else begin
                r_rm <= refl_i;
                r_rp <= $signed({2'b00, refl_n, 1'b0}) - 15'sd2;
            end
        end else if (r_rm < 15'sd0) begin
            r_rm <= r_rm + r_rp;
        end else if (r_rm >= r_rp) begin
            r_rm <= r_rm - r_rp;
        end
    end

    // raster position, frame sum and row bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= sfm_pkg::WidthReset;
            r_height_cfg <= sfm_pkg::HeightReset;
            r_col        <= '0;
            r_row        <= '0;
            r_sum        <= '0;
            r_any        <= 1'b0;
            r_frame_end  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sfm_pkg::REG_FRAME_WIDTH: begin
                    r_width_cfg <= i_cfg_wdata;
                end
                sfm_pkg::REG_FRAME_HEIGHT: begin
                    r_height_cfg <= i_cfg_wdata;
                end
                default: begin
                    r_width_cfg <= r_width_cfg;
                end
            endcase
            r_col <= '0;
            r_row <= '0;
            r_sum <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (!row_end) begin
                    r_col <= col_cur + 1'b1;
                end else begin
                    r_col       <= '0;
                    r_frame_end <= last_row;
                    r_any       <= last_row | row_ge;
                    r_row       <= last_row ? 12'd0 : r_row + 12'd1;
                end
            end
            if (i_cmd.s_acc) begin
                r_sum <= r_sum + 42'(pix_val);
            end else if (i_cmd.m_res) begin
                r_sum <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && row_end) begin
            r_prow  <= row_ge ? r_row - 12'(sfm_pkg::Radius) : 12'd0;
            r_plast <= last_row ? r_row : r_row - 12'(sfm_pkg::Radius);
        end else if (i_cmd.row_next) begin
            r_prow <= r_prow + 12'd1;
        end
    end

    // column and tap counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_init) begin
            r_c <= '0;
        end else if (i_cmd.vstore || i_cmd.s_acc) begin
            r_c <= o_status.col_last ? '0 : r_c + 1'b1;
        end
        if (i_cmd.vcol_init || i_cmd.hcol_init) begin
            r_tap <= '0;
        end else if (i_cmd.vmac || i_cmd.hmac) begin
            r_tap <= r_tap + 1'b1;
        end
    end

    // line store: reference in the upper byte, test in the lower
    assign wr_addr = {slot_of(r_row), col_cur};
    assign rd_addr = {slot_of(refl_val), r_c};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem_line[wr_addr] <= {i_ref_pixel, i_test_pixel};
        end
        if (i_cmd.vread) begin
            r_line_q <= mem_line[rd_addr];
        end
    end

    // column store of the five vertical sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.vstore) begin
            mem_col[r_c] <= {r_vacc[4], r_vacc[3], r_vacc[2], r_vacc[1], r_vacc[0]};
        end
        if (i_cmd.hread) begin
            r_col_q <= mem_col[refl_val[CB-1:0]];
        end
    end

    // vertical pass: x, y, xx, yy, xy
    always_ff @(posedge i_clk) begin
        if (i_cmd.vsq) begin
            r_sq[0] <= {8'd0, r_line_q[15:8]};
            r_sq[1] <= {8'd0, r_line_q[7:0]};
            r_sq[2] <= 16'(r_line_q[15:8]) * 16'(r_line_q[15:8]);
            r_sq[3] <= 16'(r_line_q[7:0]) * 16'(r_line_q[7:0]);
            r_sq[4] <= 16'(r_line_q[15:8]) * 16'(r_line_q[7:0]);
        end
        for (int j = 0; j < 5; j++) begin
            if (i_cmd.vcol_init) begin
                r_vacc[j] <= '0;
            end else if (i_cmd.vmac) begin
                r_vacc[j] <= r_vacc[j] + 32'(k) * 32'(r_sq[j]);
            end
        end
    end

    // horizontal pass
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            colq[j]  = r_col_q[j*32 +: 32];
            hprod[j] = 48'(k) * 48'(colq[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 5; j++) begin
            if (i_cmd.hcol_init) begin
                r_hacc[j] <= '0;
            end else if (i_cmd.hmac) begin
                r_hacc[j] <= r_hacc[j] + hprod[j];
            end
        end
    end

    // per pixel ssim terms
    always_comb begin
        ta_raw   = $signed({3'b000, r_p12, 1'b0});
        tb_raw   = ($signed({4'b0000, r_hacc[4]}) - $signed({4'b0000, r_p12})) <<< 1;
        tp_raw   = $signed({4'b0000, r_p11}) + $signed({4'b0000, r_p22});
        tq_raw   = ($signed({4'b0000, r_hacc[2]}) - $signed({4'b0000, r_p11}))
                 + ($signed({4'b0000, r_hacc[3]}) - $signed({4'b0000, r_p22}));
        den_prod = 56'(r_tp) * 56'(r_tq);
        num_mag  = r_num[55] ? unsigned'(-r_num) : unsigned'(r_num);
        den_mag  = unsigned'(r_den);
        pix_mag  = r_sat ? 17'd65536 : {1'b0, div_q[15:0]};
        pix_val  = r_neg ? -$signed({1'b0, pix_mag}) : $signed({1'b0, pix_mag});
        sum_mag  = r_sum[41] ? unsigned'(-r_sum) : unsigned'(r_sum);
        area     = 24'(eff_w) * 24'(eff_h);
        mean_mag = div_q[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.s_mean) begin
            r_m1 <= 24'((r_hacc[0] + 48'd32768) >> 16);
            r_m2 <= 24'((r_hacc[1] + 48'd32768) >> 16);
        end
        if (i_cmd.s_mul1) begin
            r_p12 <= 48'(r_m1) * 48'(r_m2);
            r_p11 <= 48'(r_m1) * 48'(r_m1);
            r_p22 <= 48'(r_m2) * 48'(r_m2);
        end
        if (i_cmd.s_term) begin
            r_ta <= round_q25(ta_raw) + sfm_pkg::C1Q7;
            r_tb <= round_q25(tb_raw) + sfm_pkg::C2Q7;
            r_tp <= round_q25(tp_raw) + sfm_pkg::C1Q7;
            r_tq <= round_q25(tq_raw) + sfm_pkg::C2Q7;
        end
        if (i_cmd.s_mul2) begin
            r_num <= 56'(r_ta) * 56'(r_tb);
            r_den <= (den_prod < 56'sd1) ? 56'sd1 : den_prod;
        end
        if (i_cmd.s_div) begin
            // ratio at or beyond one saturates; the divider still runs but its quotient is unused
            r_sat <= num_mag >= den_mag;
            r_neg <= r_num[55];
        end
        if (i_cmd.m_res) begin
            r_frame_ssim <= r_sum[41] ? -$signed(mean_mag) : $signed(mean_mag);
        end
    end

    // shared divider: per pixel ratio or frame mean
    always_comb begin
        div_start = i_cmd.s_div | i_cmd.m_div;
        if (i_cmd.m_div) begin
            div_dividend = sfm_pkg::DivNumBits'(sum_mag);
            div_divisor  = sfm_pkg::DivDenBits'(area);
        end else begin
            div_dividend = {num_mag[47:0], 16'd0};
            div_divisor  = den_mag[sfm_pkg::DivDenBits-1:0];
        end
    end

    sfm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    always_comb begin
        o_status.row_end      = row_end;
        o_status.rows_pending = r_any;
        o_status.frame_end    = r_frame_end;
        o_status.refl_done    = refl_done;
        o_status.tap_last     = (r_tap == TB'(sfm_pkg::Span - 1));
        o_status.col_last     = ({1'b0, r_c} == wm1);
        o_status.row_last     = (r_prow == r_plast);
        o_status.div_busy     = div_busy;
    end

    assign o_frame_ssim = r_frame_ssim;

endmodule

// File: src/sfm_ctrl.sv
// sequencer for row processing and the frame result
module sfm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pix_valid,
    input  logic              i_res_stall,
    input  sfm_pkg::t_status  i_status,
    output sfm_pkg::t_cmd     o_cmd,
    output logic              o_pix_stall,
    output logic              o_res_valid
);

    sfm_pkg::t_state r_state;
    sfm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_pix_stall = 1'b1;
        o_res_valid = 1'b0;
        case (r_state)
            sfm_pkg::ST_IDLE: begin
                o_pix_stall  = 1'b0;
                o_cmd.accept = i_pix_valid;
                if (i_pix_valid && i_status.row_end) begin
                    n_state = sfm_pkg::ST_ROW_CHK;
                end
            end
            sfm_pkg::ST_ROW_CHK: begin
                if (i_status.rows_pending) begin
                    o_cmd.row_init = 1'b1;
                    n_state        = sfm_pkg::ST_V_COL;
                end else begin
                    n_state = sfm_pkg::ST_IDLE;
                end
            end
            sfm_pkg::ST_V_COL: begin
                o_cmd.vcol_init = 1'b1;
                n_state         = sfm_pkg::ST_V_RSTART;
            end
            sfm_pkg::ST_V_RSTART: begin
                o_cmd.refl_row = 1'b1;
                n_state        = sfm_pkg::ST_V_RWAIT;
            end
            sfm_pkg::ST_V_RWAIT: begin
                if (i_status.refl_done) begin
                    o_cmd.vread = 1'b1;
                    n_state     = sfm_pkg::ST_V_SQ;
                end
            end
            sfm_pkg::ST_V_SQ: begin
                o_cmd.vsq = 1'b1;
                n_state   = sfm_pkg::ST_V_MAC;
            end
            sfm_pkg::ST_V_MAC: begin
                o_cmd.vmac = 1'b1;
                n_state    = i_status.tap_last ? sfm_pkg::ST_V_STORE : sfm_pkg::ST_V_RSTART;
            end
            sfm_pkg::ST_V_STORE: begin
                o_cmd.vstore = 1'b1;
                n_state      = i_status.col_last ? sfm_pkg::ST_H_COL : sfm_pkg::ST_V_COL;
            end
            sfm_pkg::ST_H_COL: begin
                o_cmd.hcol_init = 1'b1;
                n_state         = sfm_pkg::ST_H_RSTART;
            end
            sfm_pkg::ST_H_RSTART: begin
                o_cmd.refl_col = 1'b1;
                n_state        = sfm_pkg::ST_H_RWAIT;
            end
            sfm_pkg::ST_H_RWAIT: begin
                if (i_status.refl_done) begin
                    o_cmd.hread = 1'b1;
                    n_state     = sfm_pkg::ST_H_MAC;
                end
            end
            sfm_pkg::ST_H_MAC: begin
                o_cmd.hmac = 1'b1;
                n_state    = i_status.tap_last ? sfm_pkg::ST_S_MEAN : sfm_pkg::ST_H_RSTART;
            end
            sfm_pkg::ST_S_MEAN: begin
                o_cmd.s_mean = 1'b1;
                n_state      = sfm_pkg::ST_S_MUL1;
            end
            sfm_pkg::ST_S_MUL1: begin
                o_cmd.s_mul1 = 1'b1;
                n_state      = sfm_pkg::ST_S_TERM;
            end
            sfm_pkg::ST_S_TERM: begin
                o_cmd.s_term = 1'b1;
                n_state      = sfm_pkg::ST_S_MUL2;
            end
            sfm_pkg::ST_S_MUL2: begin
                o_cmd.s_mul2 = 1'b1;
                n_state      = sfm_pkg::ST_S_DIV;
            end
            sfm_pkg::ST_S_DIV: begin
                o_cmd.s_div = 1'b1;
                n_state     = sfm_pkg::ST_S_DWAIT;
            end
            sfm_pkg::ST_S_DWAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.s_acc = 1'b1;
                    n_state     = i_status.col_last ? sfm_pkg::ST_ROW_NEXT : sfm_pkg::ST_H_COL;
                end
            end
            sfm_pkg::ST_ROW_NEXT: begin
                if (!i_status.row_last) begin
                    o_cmd.row_next = 1'b1;
                    n_state        = sfm_pkg::ST_V_COL;
                end else if (i_status.frame_end) begin
                    n_state = sfm_pkg::ST_M_DIV;
                end else begin
                    n_state = sfm_pkg::ST_IDLE;
                end
            end
            sfm_pkg::ST_M_DIV: begin
                o_cmd.m_div = 1'b1;
                n_state     = sfm_pkg::ST_M_DWAIT;
            end
            sfm_pkg::ST_M_DWAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.m_res = 1'b1;
                    n_state     = sfm_pkg::ST_OUT;
                end
            end
            sfm_pkg::ST_OUT: begin
                o_res_valid = 1'b1;
                if (!i_res_stall) begin
                    n_state = sfm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sfm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/ssim_frame_metric_unit.sv
// top level of the ssim frame metric unit
// Takes reference and test luma pairs in raster order and, after the frame's last pixel,
// gives the frame mean SSIM (11x11 Gaussian window, sigma 1.5, mirrored borders) as
// signed Q1.16. Pixels that do not end a row are taken back to back. A pixel that ends a
// row starts work on the row five lines up, held in single-port line and column stores:
// the vertical pass runs the 11 taps (mirror, read, square, accumulate) for each column,
// then the horizontal pass runs the 11 taps (mirror, read, accumulate) and the per-pixel
// ratio math, dominated by the bit-serial divider, for each column; near the borders the
// mirror folds the tap index first. Input is stalled during this row work.
// The last row of a frame also finishes the remaining bottom rows and one more division
// for the mean; the result then waits in its output register until taken, and no input
// is taken meanwhile. The line stores need no clearing after reset. A write to either
// size register restarts the frame.
module ssim_frame_metric_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [11:0]        i_cfg_wdata,
    input  logic               i_pix_valid,
    output logic               o_pix_stall,
    input  logic [7:0]         i_ref_pixel,
    input  logic [7:0]         i_test_pixel,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic signed [17:0] o_frame_ssim
);

    sfm_pkg::t_cmd    cmd;
    sfm_pkg::t_status status;

    sfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .i_res_stall (i_res_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_pix_stall (o_pix_stall),
        .o_res_valid (o_res_valid)
    );

    sfm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_ref_pixel  (i_ref_pixel),
        .i_test_pixel (i_test_pixel),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_frame_ssim (o_frame_ssim)
    );

endmodule

// File: src/sfm_checker.sv
// port checks of the ssim frame metric unit and their bind
module sfm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_pix_valid,
    input logic               o_pix_stall,
    input logic               o_res_valid,
    input logic               i_res_stall,
    input logic signed [17:0] o_frame_ssim
);

    // a waiting result keeps its value
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_frame_ssim))
        else $error("frame result changed while stalled");

    // no pixel transfer while a result is pending
    a_stall_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_pix_stall)
        else $error("input open while result pending");

    // mean stays within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_frame_ssim <= 18'sd65536 && o_frame_ssim >= -18'sd65536))
        else $error("frame ssim out of range");

    // reset leaves no result behind
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind ssim_frame_metric_unit sfm_checker u_chk (.*);

// File: tb/sv/tb.sv
// testbench for the ssim frame metric unit: random traffic checked against a frame ssim predictor
`timescale 1ns / 100ps

module tb;

    // tracks line stores, raster position and ratio sum; predicts the frame mean ssim
    class frame_ssim_tracker;
        byte unsigned ref_rows [sfm_pkg::Span][sfm_pkg::MaxWidth];
        byte unsigned test_rows [sfm_pkg::Span][sfm_pkg::MaxWidth];
        longint       taps [sfm_pkg::Span];
        longint       col_sx [sfm_pkg::MaxWidth];
        longint       col_sy [sfm_pkg::MaxWidth];
        longint       col_sxx [sfm_pkg::MaxWidth];
        longint       col_syy [sfm_pkg::MaxWidth];
        longint       col_sxy [sfm_pkg::MaxWidth];
        logic [11:0]  width_reg;
        logic [11:0]  height_reg;
        int           col_pos;
        int           row_pos;
        longint       ratio_sum;
        logic signed [17:0] expected_means [$];
        int           errors;
        int           frames_checked;

        function new();
            longint raw [8] = '{65536, 52477, 26943, 8869, 1872, 253, 22, 1};
            longint tot;
            longint side;
            longint wt;
            tot  = raw[0];
            side = 0;
            for (int d = 1; d <= sfm_pkg::Radius; d++) tot += 2 * raw[d];
            for (int d = 1; d <= sfm_pkg::Radius; d++) begin
                wt = (raw[d] * 65536 + tot / 2) / tot;
                taps[sfm_pkg::Radius + d] = wt;
                taps[sfm_pkg::Radius - d] = wt;
                side += wt;
            end
            taps[sfm_pkg::Radius] = 65536 - 2 * side;
            foreach (ref_rows[s, c]) begin
                ref_rows[s][c]  = 0;
                test_rows[s][c] = 0;
            end
            width_reg      = sfm_pkg::WidthReset;
            height_reg     = sfm_pkg::HeightReset;
            col_pos        = 0;
            row_pos        = 0;
            ratio_sum      = 0;
            errors         = 0;
            frames_checked = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            return (width_reg > sfm_pkg::MaxWidth) ? sfm_pkg::MaxWidth : int'(width_reg);
        endfunction

        function int eff_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        // reflect-101 mirror, periodic for tiny sizes
        function int mirror(int i, int n);
            int p;
            int m;
            if (n <= 1) return 0;
            p = 2 * (n - 1);
            m = i % p;
            if (m < 0) m += p;
            if (m >= n) m = p - m;
            return m;
        endfunction

        // Q.32 to Q.7, nearest with ties away from zero
        function longint to_q7(longint v);
            if (v >= 0) return (v + (64'sd1 <<< 24)) >>> 25;
            return -((-v + (64'sd1 <<< 24)) >>> 25);
        endfunction

        function void write_reg(sfm_pkg::t_reg_index idx, logic [11:0] val);
            if (idx == sfm_pkg::REG_FRAME_WIDTH) width_reg = val;
            else height_reg = val;
            col_pos   = 0;
            row_pos   = 0;
            ratio_sum = 0;
        endfunction

        function void sum_row(int r, int w, int h);
            longint sx, sy, sxx, syy, sxy, k, x, y;
            longint m1, m2, a, b, p, q, num, den, val;
            int slot;
            int cc;
            for (int c = 0; c < w; c++) begin
                sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
                for (int d = -sfm_pkg::Radius; d <= sfm_pkg::Radius; d++) begin
                    slot = mirror(r + d, h) % sfm_pkg::Span;
                    x = ref_rows[slot][c];
                    y = test_rows[slot][c];
                    k = taps[d + sfm_pkg::Radius];
                    sx += k * x; sy += k * y;
                    sxx += k * x * x; syy += k * y * y; sxy += k * x * y;
                end
                col_sx[c] = sx; col_sy[c] = sy;
                col_sxx[c] = sxx; col_syy[c] = syy; col_sxy[c] = sxy;
            end
            for (int c = 0; c < w; c++) begin
                sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
                for (int d = -sfm_pkg::Radius; d <= sfm_pkg::Radius; d++) begin
                    cc = mirror(c + d, w);
                    k = taps[d + sfm_pkg::Radius];
                    sx += k * col_sx[cc]; sy += k * col_sy[cc];
                    sxx += k * col_sxx[cc]; syy += k * col_syy[cc];
                    sxy += k * col_sxy[cc];
                end
                m1 = (sx + 32768) >>> 16;
                m2 = (sy + 32768) >>> 16;
                a = to_q7(2 * m1 * m2) + 832;
                b = to_q7(2 * (sxy - m1 * m2)) + 7491;
                p = to_q7(m1 * m1 + m2 * m2) + 832;
                q = to_q7((sxx - m1 * m1) + (syy - m2 * m2)) + 7491;
                num = a * b;
                den = p * q;
                if (den < 1) den = 1;
                val = (num * 65536) / den;
                if (val > 65536) val = 65536;
                if (val < -65536) val = -65536;
                ratio_sum += val;
            end
        endfunction

        function void note_pixel(logic [7:0] x, logic [7:0] y);
            int w, h, col, k, first;
            longint mean;
            w   = eff_width();
            h   = eff_height();
            col = (col_pos >= w) ? w - 1 : col_pos;
            k   = row_pos;
            ref_rows[k % sfm_pkg::Span][col]  = x;
            test_rows[k % sfm_pkg::Span][col] = y;
            if (col + 1 < w) begin
                col_pos = col + 1;
                return;
            end
            col_pos = 0;
            if (k >= sfm_pkg::Radius) sum_row(k - sfm_pkg::Radius, w, h);
            if (k + 1 < h) begin
                row_pos = k + 1;
                return;
            end
            // bottom rows not yet covered by the window
            first = (k >= sfm_pkg::Radius) ? k - sfm_pkg::Radius + 1 : 0;
            for (int r = first; r <= k; r++) sum_row(r, w, h);
            mean = ratio_sum / (longint'(w) * longint'(h));
            expected_means.insert(expected_means.size(), mean[17:0]);
            row_pos   = 0;
            ratio_sum = 0;
        endfunction

        function void check_result(logic signed [17:0] got);
            logic signed [17:0] want;
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected frame result, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = expected_means.pop_front();
            frames_checked++;
            if (got !== want) begin
                $display("%0t: frame_ssim mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic               i_cfg_index;
    logic [11:0]        i_cfg_wdata;
    logic               i_pix_valid;
    logic               o_pix_stall;
    logic [7:0]         i_ref_pixel;
    logic [7:0]         i_test_pixel;
    logic               o_res_valid;
    logic               i_res_stall;
    logic signed [17:0] o_frame_ssim;

    frame_ssim_tracker tracker;
    bit  idle_on;
    int  hold_cycles;
    int  pixels_sent;
    int  frames_sent;

    ssim_frame_metric_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pix_valid  (i_pix_valid),
        .o_pix_stall  (o_pix_stall),
        .i_ref_pixel  (i_ref_pixel),
        .i_test_pixel (i_test_pixel),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_frame_ssim (o_frame_ssim)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // result side: long hold-offs on request, random stalls otherwise while idling is on
    initial begin
        i_res_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && !i_res_stall) tracker.check_result(o_frame_ssim);
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_res_stall = 1'b1;
                hold_cycles--;
            end else begin
                i_res_stall = idle_on && ($urandom_range(99) < 37);
            end
        end
    end

    task automatic write_cfg(sfm_pkg::t_reg_index idx, logic [11:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        tracker.write_reg(idx, val);
    endtask

    task automatic send_pixel(logic [7:0] x, logic [7:0] y);
        while (idle_on && $urandom_range(99) < 37) begin
            i_pix_valid = 1'b0;
            @(negedge i_clk);
        end
        i_pix_valid  = 1'b1;
        i_ref_pixel  = x;
        i_test_pixel = y;
        forever begin
            @(posedge i_clk);
            if (!o_pix_stall) break;
        end
        tracker.note_pixel(x, y);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_pix_valid = 1'b0;
    endtask

    // wait for all results, then let any row work in flight finish before a write
    task automatic drain(int settle);
        stop_sending();
        while (tracker.expected_means.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // one frame (or the first n pixels of it) with a content style
    task automatic send_frame(int n, int style);
        logic [7:0] x;
        logic [7:0] y;
        for (int i = 0; i < n; i++) begin
            x = $urandom_range(255);
            case (style)
                0: y = $urandom_range(255);
                1: y = x;
                2: y = ~x;
                3: y = (x > 8'd240) ? 8'd255 : x + 8'($urandom_range(15));
                default: begin
                    x = 8'd128;
                    y = 8'd128;
                end
            endcase
            send_pixel(x, y);
        end
        frames_sent++;
    endtask

    initial begin
        int w;
        int h;
        tracker      = new();
        idle_on      = 1'b1;
        hold_cycles  = 0;
        pixels_sent  = 0;
        frames_sent  = 0;
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = sfm_pkg::REG_FRAME_WIDTH;
        i_cfg_wdata  = '0;
        i_pix_valid  = 1'b0;
        i_ref_pixel  = '0;
        i_test_pixel = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero sizes count as one: every pixel is a whole frame
        write_cfg(sfm_pkg::REG_FRAME_WIDTH, 12'd0);
        write_cfg(sfm_pkg::REG_FRAME_HEIGHT, 12'd0);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd0, 8'd255);
        drain(50);
        // results held back while the sender keeps offering
        hold_cycles = 3000;
        send_frame(4, 0);
        drain(50);

        // tiny frames exercise the periodic mirror
        write_cfg(sfm_pkg::REG_FRAME_WIDTH, 12'd3);
        write_cfg(sfm_pkg::REG_FRAME_HEIGHT, 12'd2);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd128, 8'd127);
        send_pixel(8'd1, 8'd254);
        drain(50);

        // register extremes: oversized width saturates, partial frame then restart
        write_cfg(sfm_pkg::REG_FRAME_WIDTH, 12'd4095);
        write_cfg(sfm_pkg::REG_FRAME_HEIGHT, 12'd4095);
        send_frame(6, 0);
        drain(1000);

        // a 16x16 frame, no idling on either side
        idle_on = 1'b0;
        write_cfg(sfm_pkg::REG_FRAME_WIDTH, 12'd16);
        write_cfg(sfm_pkg::REG_FRAME_HEIGHT, 12'd16);
        send_frame(256, 3);
        drain(50);
        idle_on = 1'b1;

        while (pixels_sent < 650) begin
            w = $urandom_range(7);
            h = $urandom_range(7);
            write_cfg(sfm_pkg::REG_FRAME_WIDTH, 12'(w));
            write_cfg(sfm_pkg::REG_FRAME_HEIGHT, 12'(h));
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            repeat ($urandom_range(1, 2)) send_frame(w * h, $urandom_range(4));
            if ($urandom_range(9) == 0) begin
                // broken frame: cut short, then the next write restarts it
                send_frame($urandom_range(w * h - 1), 0);
                drain(400 * w + 1000);
            end else begin
                drain(50);
            end
        end

        drain(2000);
        $display("tb: %0d pixel transfers in %0d frames, %0d frame results checked, %0d errors",
                 pixels_sent, frames_sent, tracker.frames_checked, tracker.errors);
        $display("tb: sizes from zero and tiny through 16x16, register extremes, result hold-off");
        if (tracker.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/sfm_pkg.sv
src/sfm_divider.sv
src/sfm_datapath.sv
src/sfm_ctrl.sv
src/ssim_frame_metric_unit.sv
src/sfm_checker.sv
tb/sv/tb.sv
